FILE: design/i2cm_pkg.sv
// Shared types and constants for the I2C master bit engine.
`timescale 1ns / 1ps

package i2cm_pkg;

    // Command codes
    localparam logic [2:0] OP_NONE  = 3'd0;
    localparam logic [2:0] OP_START = 3'd1;
    localparam logic [2:0] OP_STOP  = 3'd2;
    localparam logic [2:0] OP_WRITE = 3'd3;
    localparam logic [2:0] OP_READ  = 3'd4;
    localparam logic [2:0] OP_WAIT  = 3'd5;

    localparam logic [7:0] ACK_TIMEOUT_RESET = 8'd100;
    localparam logic [3:0] BITS_PER_BYTE     = 4'd8;

    typedef struct packed {
        logic [1:0] phase;
        logic [3:0] bit_count;
        logic [7:0] shift_reg;
        logic [2:0] active_op;
        logic [7:0] poll_count;
        logic       scl_level;
        logic       sda_level;
        logic [7:0] received;
        logic       fail_flag;
        logic       ack_choice;
    } seq_state_t;

    typedef struct packed {
        logic       scl;
        logic       sda_out;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_failed;
    } tick_res_t;

    localparam seq_state_t SEQ_STATE_RESET = '{
        phase:      2'd0,
        bit_count:  4'd0,
        shift_reg:  8'd0,
        active_op:  OP_NONE,
        poll_count: 8'd0,
        scl_level:  1'b1,
        sda_level:  1'b1,
        received:   8'd0,
        fail_flag:  1'b0,
        ack_choice: 1'b0
    };

endpackage

FILE: design/i2cm_step.sv
// Per-tick next-state and pin-level logic of the I2C master sequencer.
`timescale 1ns / 1ps

module i2cm_step
    import i2cm_pkg::*;
(
    input  seq_state_t state_i,
    input  logic [2:0] operation_i,
    input  logic [7:0] tx_byte_i,
    input  logic       send_ack_i,
    input  logic       sda_in_i,
    input  logic [7:0] ack_timeout_i,
    output seq_state_t state_o,
    output tick_res_t  res_o
);

    seq_state_t st;
    seq_state_t nxt;
    logic       scl;
    logic       sda;
    logic       busy;
    logic       done;
    logic       rest_scl;

    always_comb begin
        st = state_i;
        // new command only when idle; codes 6 and 7 count as none
        if (state_i.active_op == OP_NONE && operation_i >= OP_START
                && operation_i <= OP_WAIT) begin
            st.active_op  = operation_i;
            st.phase      = 2'd0;
            st.bit_count  = 4'd0;
            st.shift_reg  = (operation_i == OP_WRITE) ? tx_byte_i : 8'd0;
            st.ack_choice = send_ack_i;
            st.poll_count = 8'd0;
        end

        nxt      = st;
        scl      = st.scl_level;
        sda      = st.sda_level;
        busy     = 1'b0;
        done     = 1'b0;
        rest_scl = 1'b0;

        if (st.active_op != OP_NONE) begin
            busy = 1'b1;
            unique case (st.active_op)
                OP_START: begin
                    scl = 1'b1;
                    sda = (st.phase == 2'd0);
                    if (st.phase == 2'd0) nxt.phase = 2'd1;
                    else done = 1'b1;
                end
                OP_STOP: begin
                    scl      = 1'b1;
                    sda      = (st.phase != 2'd0);
                    rest_scl = 1'b1;
                    if (st.phase == 2'd0) nxt.phase = 2'd1;
                    else done = 1'b1;
                end
                OP_WRITE: begin
                    sda = st.shift_reg[7];
                    scl = (st.phase == 2'd1);
                    if (st.phase < 2'd2) begin
                        nxt.phase = st.phase + 2'd1;
                    end else begin
                        nxt.phase     = 2'd0;
                        nxt.shift_reg = {st.shift_reg[6:0], 1'b0};
                        if (st.bit_count >= BITS_PER_BYTE - 4'd1) done = 1'b1;
                        else nxt.bit_count = st.bit_count + 4'd1;
                    end
                end
                OP_READ: begin
                    scl = st.phase[0];
                    if (st.bit_count < BITS_PER_BYTE) begin
                        sda = 1'b1;
                        if (st.phase == 2'd0) begin
                            nxt.phase = 2'd1;
                        end else begin
                            // sample on the SCL-high tick
                            nxt.shift_reg = {st.shift_reg[6:0], sda_in_i};
                            nxt.phase     = 2'd0;
                            nxt.bit_count = st.bit_count + 4'd1;
                        end
                    end else begin
                        sda = ~st.ack_choice;
                        if (st.phase == 2'd0) begin
                            nxt.phase = 2'd1;
                        end else begin
                            nxt.received = st.shift_reg;
                            done         = 1'b1;
                        end
                    end
                end
                default: begin // wait for ACK
                    scl = 1'b1;
                    if (st.phase == 2'd0) begin
                        sda       = 1'b1;
                        nxt.phase = 2'd1;
                    end else if (st.phase == 2'd1) begin
                        sda = 1'b1;
                        if (!sda_in_i) begin
                            nxt.fail_flag = 1'b0;
                            done          = 1'b1;
                        end else if (st.poll_count >= ack_timeout_i) begin
                            nxt.phase = 2'd2;
                        end else begin
                            nxt.poll_count = st.poll_count + 8'd1;
                        end
                    end else if (st.phase == 2'd2) begin
                        // forced stop, first half
                        sda       = 1'b0;
                        nxt.phase = 2'd3;
                    end else begin
                        sda           = 1'b1;
                        nxt.fail_flag = 1'b1;
                        rest_scl      = 1'b1;
                        done          = 1'b1;
                    end
                end
            endcase
            nxt.sda_level = sda;
            nxt.scl_level = done ? rest_scl : scl;
            if (done) begin
                nxt.active_op = OP_NONE;
                nxt.phase     = 2'd0;
                nxt.bit_count = 4'd0;
            end
        end

        state_o          = nxt;
        res_o.scl        = scl;
        res_o.sda_out    = sda;
        res_o.busy_res   = busy;
        res_o.done_res   = done;
        res_o.rx_byte    = nxt.received;
        res_o.ack_failed = nxt.fail_flag;
    end

endmodule

FILE: design/i2c_master_bit_engine_top.sv
// Top level of the I2C master bit engine: handshake, state and result registers.
// The result of an accepted tick transfer is registered and is valid in the cycle after it is accepted.
// One tick is taken per clock while s_ready is high; the sequencer state updates once per transfer.
// The result register frees up in the cycle it is taken, so s_ready stays high under
// continuous m_ready; a stalled result holds s_ready low until it is taken.
// Reset (aresetn low, synchronous): idle, both lines released high, ack_timeout = 100.
`timescale 1ns / 1ps

module i2c_master_bit_engine_top
    import i2cm_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    // configuration: ack_timeout
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata,
    // tick input channel
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [2:0] s_operation,
    input  logic [7:0] s_tx_byte,
    input  logic       s_send_ack,
    input  logic       s_sda_in,
    // tick result channel
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_scl,
    output logic       m_sda_out,
    output logic       m_busy_res,
    output logic       m_done_res,
    output logic [7:0] m_rx_byte,
    output logic       m_ack_failed
);

    seq_state_t state_reg;
    seq_state_t state_next;
    tick_res_t  res_reg;
    tick_res_t  res_next;
    logic       m_valid_reg;
    logic [7:0] ack_timeout_reg;
    logic       in_xfer;

    // The result register is the only buffer: take a new tick when it is
    // empty or being drained this cycle.
    assign s_ready = !m_valid_reg || m_ready;
    assign in_xfer = s_valid && s_ready;

    // Sequencer step: one transfer advances the pin sequence by one tick.
    i2cm_step u_step (
        .state_i       (state_reg),
        .operation_i   (s_operation),
        .tx_byte_i     (s_tx_byte),
        .send_ack_i    (s_send_ack),
        .sda_in_i      (s_sda_in),
        .ack_timeout_i (ack_timeout_reg),
        .state_o       (state_next),
        .res_o         (res_next)
    );

    // Control state and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= SEQ_STATE_RESET;
            m_valid_reg     <= 1'b0;
            ack_timeout_reg <= ACK_TIMEOUT_RESET;
        end else begin
            if (cfg_we) ack_timeout_reg <= cfg_wdata;
            if (in_xfer) begin
                state_reg   <= state_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload, no reset needed
    always_ff @(posedge aclk) begin
        if (in_xfer) res_reg <= res_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_scl        = res_reg.scl;
    assign m_sda_out    = res_reg.sda_out;
    assign m_busy_res   = res_reg.busy_res;
    assign m_done_res   = res_reg.done_res;
    assign m_rx_byte    = res_reg.rx_byte;
    assign m_ack_failed = res_reg.ack_failed;

    // An accepted tick always leaves a result behind.
    a_xfer_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer |=> m_valid)
        else $error("tick transfer produced no result");

    // An idle sequencer has its counters parked.
    a_idle_parked: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg.active_op == OP_NONE) |->
            (state_reg.phase == 2'd0 && state_reg.bit_count == 4'd0))
        else $error("idle sequencer with live phase or bit count");

    // Only a read reaches the ninth (ACK) bit slot.
    a_bit_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg.bit_count == BITS_PER_BYTE) |-> (state_reg.active_op == OP_READ))
        else $error("bit count at byte end outside a read");

    // A completing tick is always a busy tick.
    a_done_is_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_done_res) |-> m_busy_res)
        else $error("done without busy");

    // After a completed command the sequencer is idle.
    a_done_goes_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_xfer && res_next.done_res) |=> (state_reg.active_op == OP_NONE))
        else $error("sequencer still active after done");

endmodule
